>>> design/rrtt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rrtt_pkg
// Types and constants shared by the round-robin task table and its cells.
// ---------------------------------------------------------------------------
package rrtt_pkg;

  // Widths of the transaction fields.
  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 4;
  localparam int COUNT_W  = 5;

  // Width that holds any cell position or entry count up to the largest depth.
  localparam int MAX_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_YIELD  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WRAP,
    SEQ_SCAN,
    SEQ_RESP
  } seq_state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                active;
    logic [ID_W-1:0]     id;
  } entry_t;

  // Command broadcast to every cell; only checked operations are flagged.
  typedef struct packed {
    logic                start;
    logic                stop;
    logic                remove;
    logic [MAX_W-1:0]    count;
    logic [MAX_W-1:0]    index;
    logic [HANDLE_W-1:0] handle;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> design/round_robin_task_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// round_robin_task_table
// Round-robin task table built as a row of entry cells with a small
// sequencer for the yield search.
// ---------------------------------------------------------------------------
// Usage: one request channel (func_i, handle_i, task_index_i with
// in_valid_i/in_ready_o) and one response channel (status_o,
// current_index_o, current_handle_o, current_id_o, entry_count_o with
// out_valid_o/out_ready_i). Every request produces exactly one response.
// Start, stop and remove update the cells at the accepting edge; the
// response is registered from the response state once the output register
// is free. Remove shifts the cells down at that same edge, each cell taking
// its neighbor's entry. Yield first reduces (current+1) mod count in wrap
// steps of one subtraction each, then hands over to the scan, which checks
// one cell per cycle, wrapping at count, until it finds an active entry or
// has visited all count entries. A yield on an empty table needs no search
// and goes straight to the response. Requests are taken one at a time;
// in_ready_o is high only while no request is in progress, and a response
// may still wait in the output register meanwhile. If the receiver stalls,
// the next response waits in the sequencer until the output register frees
// up. Reset empties the table and sets the current pointer to zero.
// ---------------------------------------------------------------------------
module round_robin_task_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrtt_pkg::FUNC_W-1:0]      func_i,
  input  logic [rrtt_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [rrtt_pkg::IDX_W-1:0]       task_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrtt_pkg::STATUS_W-1:0]    status_o,
  output logic [rrtt_pkg::IDX_W-1:0]       current_index_o,
  output logic [rrtt_pkg::HANDLE_W-1:0]    current_handle_o,
  output logic [rrtt_pkg::ID_W-1:0]        current_id_o,
  output logic [rrtt_pkg::COUNT_W-1:0]     entry_count_o
);
  import rrtt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PTR_W = $clog2(TABLE_DEPTH);

  seq_state_e          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PTR_W-1:0]    current_q, current_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  status_e             status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_index_q, out_index_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  entry_t    cells [TABLE_DEPTH];
  cell_cmd_t cmd;

  logic             accept;
  func_e            func;
  logic [MAX_W-1:0] count_ext;
  logic [MAX_W-1:0] idx_ext;
  logic [MAX_W-1:0] cur_ext;
  logic             is_full;
  logic             in_range;
  logic             cur_valid;
  entry_t           cur_entry;
  entry_t           scan_entry;
  logic [CNT_W-1:0] pos_inc;

  assign in_ready_o = state_q == SEQ_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign func       = func_e'(func_i);
  assign count_ext  = MAX_W'(count_q);
  assign idx_ext    = MAX_W'(task_index_i);
  assign cur_ext    = MAX_W'(current_q);
  assign is_full    = count_q == CNT_W'(TABLE_DEPTH);
  assign in_range   = idx_ext < count_ext;
  assign cur_valid  = cur_ext < count_ext;
  assign cur_entry  = cells[current_q];
  assign scan_entry = cells[pos_q[PTR_W-1:0]];
  assign pos_inc    = pos_q + CNT_W'(1);

  assign cmd.start  = accept && (func == FUNC_START) && !is_full;
  assign cmd.stop   = accept && (func == FUNC_STOP) && in_range;
  assign cmd.remove = accept && (func == FUNC_REMOVE) && in_range;
  assign cmd.count  = count_ext;
  assign cmd.index  = idx_ext;
  assign cmd.handle = handle_i;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t next_entry;
    if (i < TABLE_DEPTH - 1) begin : g_inner
      assign next_entry = cells[i+1];
    end else begin : g_last
      assign next_entry = '0;
    end
    rrtt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cell_idx_i (MAX_W'(i)),
      .next_i     (next_entry),
      .entry_o    (cells[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    current_d    = current_q;
    pos_d        = pos_q;
    scan_d       = scan_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_handle_d = out_handle_q;
    out_id_d     = out_id_q;
    out_count_d  = out_count_q;

    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          state_d  = SEQ_RESP;
          status_d = STATUS_OK;
          case (func)
            FUNC_START: begin
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            FUNC_STOP: begin
              if (!in_range) begin
                status_d = STATUS_RANGE;
              end
            end
            FUNC_REMOVE: begin
              if (!in_range) begin
                status_d = STATUS_RANGE;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            default: begin
              if (count_q == '0) begin
                status_d = STATUS_NONE;
              end else begin
                pos_d   = CNT_W'(current_q) + CNT_W'(1);
                scan_d  = '0;
                state_d = SEQ_WRAP;
              end
            end
          endcase
        end
      end
      SEQ_WRAP: begin
        // The pointer can sit far beyond the count after removes.
        if (pos_q >= count_q) begin
          pos_d = pos_q - count_q;
        end else begin
          state_d = SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        if (scan_entry.active) begin
          current_d = pos_q[PTR_W-1:0];
          status_d  = STATUS_OK;
          state_d   = SEQ_RESP;
        end else if (scan_q + CNT_W'(1) == count_q) begin
          status_d = STATUS_NONE;
          state_d  = SEQ_RESP;
        end else begin
          pos_d  = (pos_inc == count_q) ? '0 : pos_inc;
          scan_d = scan_q + CNT_W'(1);
        end
      end
      SEQ_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_index_d  = cur_ext[IDX_W-1:0];
          out_handle_d = cur_valid ? cur_entry.handle : '0;
          out_id_d     = cur_valid ? cur_entry.id : '0;
          out_count_d  = count_ext[COUNT_W-1:0];
          state_d      = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      count_q     <= '0;
      current_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      current_q   <= current_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    scan_q       <= scan_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_handle_q <= out_handle_d;
    out_id_q     <= out_id_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign current_index_o  = out_index_q;
  assign current_handle_o = out_handle_q;
  assign current_id_o     = out_id_q;
  assign entry_count_o    = out_count_q;

  // The entry count never grows past the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The count only changes on the edge that accepts a request.
  a_count_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != count_d) |-> accept)
    else $error("entry count changed without a request");

  // An accepted request always leaves the idle state, so its response is owed.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != SEQ_IDLE))
    else $error("accepted request left no work in progress");

  // A new response is only loaded from the response state.
  a_resp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && (!out_valid_q || out_ready_i)) |-> (state_q == SEQ_RESP))
    else $error("response loaded outside the response state");

  // The scan position always addresses a live entry.
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SCAN) |-> ((pos_q < count_q) && (scan_q < count_q)))
    else $error("scan position outside the table");

endmodule
`default_nettype wire

>>> design/rrtt_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rrtt_cell
// One task entry: handle, active flag and id. On a remove it takes the
// entry of its upper neighbor when it lies between the removed slot and
// the end of the table.
// ---------------------------------------------------------------------------
module rrtt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrtt_pkg::cell_cmd_t            cmd_i,
  input  logic [rrtt_pkg::MAX_W-1:0]     cell_idx_i,
  input  rrtt_pkg::entry_t               next_i,
  output rrtt_pkg::entry_t               entry_o
);
  import rrtt_pkg::*;

  logic                active_q, active_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [ID_W-1:0]     id_q, id_d;

  logic [MAX_W-1:0] idx_plus;
  logic             is_append;
  logic             is_hit;
  logic             is_shift;
  logic             is_tail;

  assign idx_plus  = cell_idx_i + MAX_W'(1);
  assign is_append = cmd_i.start && (cell_idx_i == cmd_i.count);
  assign is_hit    = cell_idx_i == cmd_i.index;
  assign is_shift  = cmd_i.remove && (cell_idx_i >= cmd_i.index) && (idx_plus < cmd_i.count);
  assign is_tail   = cmd_i.remove && (idx_plus == cmd_i.count);

  always_comb begin
    active_d = active_q;
    handle_d = handle_q;
    id_d     = id_q;
    if (is_append) begin
      active_d = 1'b1;
      handle_d = cmd_i.handle;
      id_d     = cmd_i.count[ID_W-1:0];
    end else if (cmd_i.stop && is_hit) begin
      active_d = 1'b0;
    end else if (is_shift) begin
      active_d = next_i.active;
      handle_d = next_i.handle;
      id_d     = next_i.id;
    end else if (is_tail) begin
      // The slot freed at the end of the table goes inactive.
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    id_q     <= id_d;
  end

  assign entry_o.handle = handle_q;
  assign entry_o.active = active_q;
  assign entry_o.id     = id_q;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin task table. A driver feeds start,
// stop, remove and yield transactions in random bursts; every accepted
// transaction runs through a cycle-free model of the table, and the monitor
// compares each response with the oldest predicted one while the response
// side stalls on its own random pattern.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrtt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_OPS  = 950;
  localparam int DRAIN_CYCLES = 40;
  localparam longint WATCHDOG_NS = 64'd5_000_000;

  typedef struct packed {
    func_e               func;
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    index;
  } table_op_t;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    index;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  count;
  } table_resp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i = FUNC_START;
  logic [HANDLE_W-1:0] handle_i = '0;
  logic [IDX_W-1:0]    task_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    current_index_o;
  logic [HANDLE_W-1:0] current_handle_o;
  logic [ID_W-1:0]     current_id_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // Model of the table contents.
  logic [HANDLE_W-1:0] tbl_handle [TABLE_DEPTH];
  logic                tbl_active [TABLE_DEPTH];
  logic [ID_W-1:0]     tbl_id [TABLE_DEPTH];
  logic [COUNT_W-1:0]  tbl_count;
  logic [IDX_W-1:0]    tbl_current;

  table_op_t   pending_ops [$];
  table_resp_t expected_resps [$];
  table_op_t   drv_op;
  table_resp_t mon_want;

  int fail_count = 0;
  int resp_count = 0;
  int random_ops = 0;
  int shadow_count = 0;
  int op_tally [4] = '{0, 0, 0, 0};
  int status_tally [4] = '{0, 0, 0, 0};
  int burst_left = 1;
  int gap_left = 0;
  int rx_left = 0;

  round_robin_task_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .handle_i        (handle_i),
    .task_index_i    (task_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .current_index_o (current_index_o),
    .current_handle_o(current_handle_o),
    .current_id_o    (current_id_o),
    .entry_count_o   (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void table_clear();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_handle[i] = '0;
      tbl_active[i] = 1'b0;
      tbl_id[i]     = '0;
    end
    tbl_count   = '0;
    tbl_current = '0;
  endfunction

  // Applies one operation to the model and returns the response it yields.
  function automatic table_resp_t apply_table_op(table_op_t op);
    table_resp_t r;
    int          pos;
    logic        found;
    r = '0;
    r.status = STATUS_OK;
    case (op.func)
      FUNC_START: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          tbl_handle[tbl_count] = op.handle;
          tbl_active[tbl_count] = 1'b1;
          tbl_id[tbl_count]     = tbl_count[ID_W-1:0];
          tbl_count             = tbl_count + 1'b1;
        end
      end
      FUNC_STOP: begin
        if (op.index >= tbl_count) begin
          r.status = STATUS_RANGE;
        end else begin
          tbl_active[op.index] = 1'b0;
        end
      end
      FUNC_REMOVE: begin
        if (op.index >= tbl_count) begin
          r.status = STATUS_RANGE;
        end else begin
          for (int i = op.index; i + 1 < tbl_count; i++) begin
            tbl_handle[i] = tbl_handle[i + 1];
            tbl_active[i] = tbl_active[i + 1];
            tbl_id[i]     = tbl_id[i + 1];
          end
          tbl_count = tbl_count - 1'b1;
          tbl_active[tbl_count] = 1'b0;
        end
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = STATUS_NONE;
        end else begin
          // Visit every entry once, starting just past the current one.
          pos   = (int'(tbl_current) + 1) % int'(tbl_count);
          found = 1'b0;
          for (int n = 0; n < tbl_count; n++) begin
            if (!found && tbl_active[pos]) begin
              tbl_current = pos[IDX_W-1:0];
              found       = 1'b1;
            end
            pos = (pos + 1 >= tbl_count) ? 0 : pos + 1;
          end
          if (!found) r.status = STATUS_NONE;
        end
      end
    endcase
    r.index = tbl_current;
    if (tbl_current < tbl_count) begin
      r.handle = tbl_handle[tbl_current];
      r.id     = tbl_id[tbl_current];
    end
    r.count = tbl_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_op(func_e f, logic [HANDLE_W-1:0] h, logic [IDX_W-1:0] idx);
    table_op_t op;
    op.func   = f;
    op.handle = h;
    op.index  = idx;
    pending_ops.push_back(op);
    op_tally[f]++;
    // Track only the entry count, enough to aim indexes at live entries.
    if (f == FUNC_START && shadow_count < TABLE_DEPTH) shadow_count++;
    if (f == FUNC_REMOVE && idx < shadow_count) shadow_count--;
  endtask

  task automatic wait_until_drained();
    while (pending_ops.size() != 0 || in_valid_i || expected_resps.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= FUNC_START;
      handle_i     <= '0;
      task_index_i <= '0;
      burst_left   <= 1;
      gap_left     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        drv_op.func   = func_e'(func_i);
        drv_op.handle = handle_i;
        drv_op.index  = task_index_i;
        mon_want      = apply_table_op(drv_op);
        expected_resps.push_back(mon_want);
        status_tally[mon_want.status]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          drv_op        = pending_ops.pop_front();
          func_i       <= drv_op.func;
          handle_i     <= drv_op.handle;
          task_index_i <= drv_op.index;
          in_valid_i   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks responses; ready alternates between runs and stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_left     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        resp_count++;
        if (expected_resps.size() == 0) begin
          $error("response with no transaction outstanding: status %0d count %0d",
                 status_o, entry_count_o);
          fail_count++;
        end else begin
          mon_want = expected_resps.pop_front();
          check_field("status", 32'(mon_want.status), 32'(status_o));
          check_field("current_index", 32'(mon_want.index), 32'(current_index_o));
          check_field("current_handle", mon_want.handle, current_handle_o);
          check_field("current_id", 32'(mon_want.id), 32'(current_id_o));
          check_field("entry_count", 32'(mon_want.count), 32'(entry_count_o));
        end
      end
      if (rx_left != 0) begin
        rx_left <= rx_left - 1;
      end else begin
        out_ready_i <= ~out_ready_i;
        rx_left     <= out_ready_i ? $urandom_range(0, 12) : $urandom_range(0, 40);
      end
    end
  end

  initial begin : stimulus
    int                  mode;
    int                  len;
    int                  pick;
    int                  phase;
    int                  lim_start;
    int                  lim_stop;
    int                  lim_remove;
    func_e               f;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] h;

    table_clear();

    // Empty table: yield finds nothing, remove is out of range.
    push_op(FUNC_YIELD, '0, '0);
    push_op(FUNC_REMOVE, '0, 4'd15);
    push_op(FUNC_START, 32'h0000_0000, '0);
    push_op(FUNC_START, 32'hFFFF_FFFF, '0);
    push_op(FUNC_YIELD, '0, '0);
    // Removing the current entry leaves the pointer past the end.
    push_op(FUNC_REMOVE, '0, 4'd1);
    push_op(FUNC_STOP, '0, 4'd0);
    // Lone entry stopped: yield scans it once and reports no active entry.
    push_op(FUNC_YIELD, '0, '0);
    for (int k = 0; k < TABLE_DEPTH - 1; k++) push_op(FUNC_START, $urandom(), '0);
    push_op(FUNC_START, 32'h5A5A_A5A5, '0);
    push_op(FUNC_YIELD, '0, '0);
    push_op(FUNC_REMOVE, '0, 4'd15);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_until_drained();

    phase = 0;
    while (random_ops < RANDOM_OPS) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 80);
      if (len > RANDOM_OPS - random_ops) len = RANDOM_OPS - random_ops;
      // Phases lean toward filling, emptying, stopping, or a balanced mix.
      case (mode)
        0:       begin lim_start = 50; lim_stop = 60; lim_remove = 70; end
        1:       begin lim_start = 15; lim_stop = 30; lim_remove = 70; end
        2:       begin lim_start = 10; lim_stop = 55; lim_remove = 65; end
        default: begin lim_start = 30; lim_stop = 45; lim_remove = 65; end
      endcase
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < lim_start) f = FUNC_START;
        else if (pick < lim_stop) f = FUNC_STOP;
        else if (pick < lim_remove) f = FUNC_REMOVE;
        else f = FUNC_YIELD;
        if (shadow_count != 0 && $urandom_range(0, 7) != 0)
          idx = $urandom_range(0, shadow_count - 1);
        else
          idx = $urandom_range(0, 15);
        case ($urandom_range(0, 15))
          0:       h = '0;
          1:       h = '1;
          default: h = $urandom();
        endcase
        push_op(f, h, idx);
        random_ops++;
      end
      phase++;
      if (phase % 3 == 0) wait_until_drained();
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d start, %0d stop, %0d remove and %0d yield transactions; %0d responses.",
             op_tally[FUNC_START], op_tally[FUNC_STOP], op_tally[FUNC_REMOVE],
             op_tally[FUNC_YIELD], resp_count);
    $display("Status mix: ok %0d, full %0d, out of range %0d, no active entry %0d.",
             status_tally[STATUS_OK], status_tally[STATUS_FULL],
             status_tally[STATUS_RANGE], status_tally[STATUS_NONE]);
    if (fail_count == 0 && expected_resps.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> files.f
design/rrtt_pkg.sv
design/rrtt_cell.sv
design/round_robin_task_table.sv
dv/tb_top.sv
